// File: sv/lss_pkg.sv
package lss_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		MODE_PUSH     = 3'd0,
		MODE_POP      = 3'd1,
		MODE_CLEAR    = 3'd2,
		MODE_SEARCH   = 3'd3,
		MODE_REVERSE  = 3'd4,
		MODE_SORT_MIN = 3'd5,
		MODE_SORT_MAX = 3'd6,
		MODE_NOP      = 3'd7
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_CLR_FLAG,
		CELL_SRCH,
		CELL_REV,
		CELL_SORT_MIN,
		CELL_SORT_MAX
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     phase;
	} cell_ctrl_t;

endpackage

// File: sv/lifo_stack_with_search_sort_top.sv
// Bounded LIFO stack of signed 32-bit words with search, reverse and sort.
// Request channel: start with mode, push_value and search_key; a request is
// taken on a clock edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle per request, with
// top_value (1 when empty), is_empty, is_full, entry_count, found and
// overflow valid in that cycle. The receiver cannot stall the result.
// Push, pop, clear and no-op requests: result in the cycle after the request,
// busy stays low, so a new request can be taken every cycle.
// Search, reverse and sort: the row of cells runs one odd-even transposition
// pass (or one step of the search flag chain) per cycle, one pass per held
// entry; busy stays high until the last pass, and the result appears in the
// cycle after the last pass. With fewer than one entry the result comes in
// the cycle after the request and busy stays low.
// Cell 0 holds the top of the stack; push shifts the row down, pop shifts up.
// A push into a full stack is dropped and flags overflow.
// Reset empties the stack and clears busy and done; stored words are not
// cleared and are never read until pushed.
module lifo_stack_with_search_sort_top #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        mode,
	input  logic signed [lss_pkg::DATA_W-1:0] push_value,
	input  logic signed [lss_pkg::DATA_W-1:0] search_key,
	output logic                              done,
	output logic signed [lss_pkg::DATA_W-1:0] top_value,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [lss_pkg::CNT_W-1:0]         entry_count,
	output logic                              found,
	output logic                              overflow
);

	localparam int CW = $clog2(DEPTH + 1);

	lss_pkg::state_t     state_q, state_d;
	lss_pkg::mode_t      mode_q;
	lss_pkg::mode_t      mode_in;
	lss_pkg::cell_ctrl_t ctrl;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       rnd_q;
	logic signed [lss_pkg::DATA_W-1:0] key_q;
	logic                done_q, ovf_q;
	logic                accept, multi, last, full;

	logic signed [lss_pkg::DATA_W-1:0] val  [DEPTH];
	logic                              swp  [DEPTH];
	logic                              flg  [DEPTH];
	logic                              vld  [DEPTH];

	assign mode_in = lss_pkg::mode_t'(mode);
	assign accept  = start && (state_q == lss_pkg::ST_IDLE);
	assign full    = (count_q == CW'(DEPTH));
	assign multi   = ((mode_in == lss_pkg::MODE_SEARCH) || (mode_in == lss_pkg::MODE_REVERSE) ||
		(mode_in == lss_pkg::MODE_SORT_MIN) || (mode_in == lss_pkg::MODE_SORT_MAX)) &&
		(count_q != '0);
	assign last    = (rnd_q == count_q - CW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lss_pkg::ST_IDLE: if (accept && multi) state_d = lss_pkg::ST_RUN;
			lss_pkg::ST_RUN:  if (last) state_d = lss_pkg::ST_IDLE;
			default:          state_d = lss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op    = lss_pkg::CELL_HOLD;
		ctrl.phase = rnd_q[0];
		count_d    = count_q;
		unique case (state_q)
			lss_pkg::ST_IDLE: begin
				if (accept) begin
					ctrl.op = lss_pkg::CELL_CLR_FLAG;
					unique case (mode_in)
						lss_pkg::MODE_PUSH: if (!full) begin
							ctrl.op = lss_pkg::CELL_PUSH;
							count_d = count_q + CW'(1);
						end
						lss_pkg::MODE_POP: if (count_q != '0) begin
							ctrl.op = lss_pkg::CELL_POP;
							count_d = count_q - CW'(1);
						end
						lss_pkg::MODE_CLEAR: count_d = '0;
						default: ctrl.op = lss_pkg::CELL_CLR_FLAG;
					endcase
				end
			end
			lss_pkg::ST_RUN: begin
				unique case (mode_q)
					lss_pkg::MODE_SEARCH:   ctrl.op = lss_pkg::CELL_SRCH;
					lss_pkg::MODE_REVERSE:  ctrl.op = lss_pkg::CELL_REV;
					lss_pkg::MODE_SORT_MIN: ctrl.op = lss_pkg::CELL_SORT_MIN;
					lss_pkg::MODE_SORT_MAX: ctrl.op = lss_pkg::CELL_SORT_MAX;
					default:                ctrl.op = lss_pkg::CELL_HOLD;
				endcase
			end
			default: ctrl.op = lss_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::ST_IDLE;
			count_q <= '0;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
			mode_q  <= lss_pkg::MODE_NOP;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (accept && !multi) || ((state_q == lss_pkg::ST_RUN) && last);
			if (accept) begin
				mode_q <= mode_in;
				ovf_q  <= (mode_in == lss_pkg::MODE_PUSH) && full;
				rnd_q  <= '0;
			end else if (state_q == lss_pkg::ST_RUN) begin
				rnd_q <= rnd_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= search_key;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [lss_pkg::DATA_W-1:0] up_v, dn_v;
		logic                              sw_in, fl_in, lo_vld;

		assign vld[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign up_v  = push_value;
			assign sw_in = 1'b0;
		end else begin : g_mid
			assign up_v  = val[i-1];
			assign sw_in = swp[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign dn_v   = '0;
			assign fl_in  = 1'b0;
			assign lo_vld = 1'b0;
		end else begin : g_low
			assign dn_v   = val[i+1];
			assign fl_in  = flg[i+1];
			assign lo_vld = vld[i+1];
		end

		lss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.par        (1'(i % 2)),
			.valid      (vld[i]),
			.lower_valid(lo_vld),
			.up_val     (up_v),
			.dn_val     (dn_v),
			.key        (key_q),
			.swap_in    (sw_in),
			.flag_in    (fl_in),
			.swap_out   (swp[i]),
			.flag       (flg[i]),
			.val        (val[i])
		);
	end

	assign busy        = (state_q == lss_pkg::ST_RUN);
	assign done        = done_q;
	assign top_value   = (count_q == '0) ? lss_pkg::DATA_W'(1) : val[0];
	assign is_empty    = (count_q == '0);
	assign is_full     = full;
	assign entry_count = lss_pkg::CNT_W'(count_q);
	assign found       = (mode_q == lss_pkg::MODE_SEARCH) && flg[0];
	assign overflow    = ovf_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == lss_pkg::ST_IDLE))
		else $error("result strobe while sequencer running");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("request neither running nor answered");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ovf_q) |-> full)
		else $error("overflow reported while not full");

endmodule

// File: sv/lss_cell.sv
module lss_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lss_pkg::cell_ctrl_t               ctrl,
	input  logic                              par,
	input  logic                              valid,
	input  logic                              lower_valid,
	input  logic signed [lss_pkg::DATA_W-1:0] up_val,
	input  logic signed [lss_pkg::DATA_W-1:0] dn_val,
	input  logic signed [lss_pkg::DATA_W-1:0] key,
	input  logic                              swap_in,
	input  logic                              flag_in,
	output logic                              swap_out,
	output logic                              flag,
	output logic signed [lss_pkg::DATA_W-1:0] val
);

	logic signed [lss_pkg::DATA_W-1:0] val_q;
	logic signed [lss_pkg::DATA_W-1:0] val_d;
	logic                              flag_q;
	logic                              flag_d;
	logic                              pair_on;

	// this cell is the upper member of an active pair
	assign pair_on = (par == ctrl.phase) && lower_valid;

	always_comb begin
		swap_out = 1'b0;
		case (ctrl.op)
			lss_pkg::CELL_REV:      swap_out = pair_on;
			lss_pkg::CELL_SORT_MIN: swap_out = pair_on && (val_q > dn_val);
			lss_pkg::CELL_SORT_MAX: swap_out = pair_on && (val_q < dn_val);
			default:                swap_out = 1'b0;
		endcase
	end

	always_comb begin
		val_d  = val_q;
		flag_d = flag_q;
		case (ctrl.op) inside
			lss_pkg::CELL_PUSH:     val_d = up_val;
			lss_pkg::CELL_POP:      val_d = dn_val;
			lss_pkg::CELL_CLR_FLAG: flag_d = 1'b0;
			lss_pkg::CELL_SRCH:     flag_d = flag_in | (valid && (val_q == key));
			lss_pkg::CELL_REV,
			lss_pkg::CELL_SORT_MIN,
			lss_pkg::CELL_SORT_MAX: begin
				if (swap_out) begin
					val_d = dn_val;
				end else if (swap_in) begin
					val_d = up_val;
				end
			end
			default: begin
				val_d  = val_q;
				flag_d = flag_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else begin
			flag_q <= flag_d;
		end
	end

	assign val  = val_q;
	assign flag = flag_q;

endmodule

// File: sim/lifo_stack_with_search_sort_top_tb.sv
`timescale 1ns / 100ps

module lifo_stack_with_search_sort_top_tb;
	import lss_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	typedef struct {
		logic signed [DATA_W-1:0] top;
		logic                     empty;
		logic                     full;
		logic [CNT_W-1:0]         count;
		logic                     found;
		logic                     ovf;
	} stack_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [2:0]               mode = MODE_NOP;
	logic signed [DATA_W-1:0] push_value = '0;
	logic signed [DATA_W-1:0] search_key = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] top_value;
	logic                     is_empty;
	logic                     is_full;
	logic [CNT_W-1:0]         entry_count;
	logic                     found;
	logic                     overflow;

	// shadow stack: index 0 is bottom
	logic signed [DATA_W-1:0] stack_mem [DEPTH];
	int                       stack_cnt = 0;
	stack_result_t            results_q [$];
	stack_result_t            exp_r;
	int                       mismatch_cnt = 0;
	int                       requests_sent = 0;
	bit                       gaps_on = 1'b1;

	lifo_stack_with_search_sort_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.push_value (push_value),
		.search_key (search_key),
		.done       (done),
		.top_value  (top_value),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.entry_count(entry_count),
		.found      (found),
		.overflow   (overflow)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic stack_result_t apply_stack_op(mode_t m, logic signed [DATA_W-1:0] pv,
			logic signed [DATA_W-1:0] key);
		stack_result_t            r;
		logic signed [DATA_W-1:0] tmp;
		bit                       swap;
		r.found = 1'b0;
		r.ovf   = 1'b0;
		case (m) inside
			MODE_PUSH: begin
				if (stack_cnt >= DEPTH) begin
					r.ovf = 1'b1;
				end else begin
					stack_mem[stack_cnt] = pv;
					stack_cnt++;
				end
			end
			MODE_POP: begin
				if (stack_cnt > 0)
					stack_cnt--;
			end
			MODE_CLEAR: stack_cnt = 0;
			MODE_SEARCH: begin
				for (int i = 0; i < stack_cnt; i++)
					if (stack_mem[i] == key)
						r.found = 1'b1;
			end
			MODE_REVERSE: begin
				for (int i = 0; i < stack_cnt / 2; i++) begin
					tmp = stack_mem[i];
					stack_mem[i] = stack_mem[stack_cnt - 1 - i];
					stack_mem[stack_cnt - 1 - i] = tmp;
				end
			end
			MODE_SORT_MIN, MODE_SORT_MAX: begin
				// sort max puts the largest on top (ascending bottom to top), sort min the smallest
				for (int i = 0; i < stack_cnt - 1; i++)
					for (int j = 0; j < stack_cnt - 1 - i; j++) begin
						swap = (m == MODE_SORT_MAX) ? (stack_mem[j] > stack_mem[j + 1])
							: (stack_mem[j] < stack_mem[j + 1]);
						if (swap) begin
							tmp = stack_mem[j];
							stack_mem[j] = stack_mem[j + 1];
							stack_mem[j + 1] = tmp;
						end
					end
			end
			default: ;
		endcase
		r.top   = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : 32'sd1;
		r.empty = (stack_cnt == 0);
		r.full  = (stack_cnt >= DEPTH);
		r.count = CNT_W'(stack_cnt);
		return r;
	endfunction

	function automatic void check_field(string field, logic [DATA_W-1:0] exp_v,
			logic [DATA_W-1:0] act_v);
		if (act_v !== exp_v) begin
			if (mismatch_cnt < 100)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, exp_v, act_v);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (results_q.size() == 0) begin
				if (mismatch_cnt < 100)
					$display("%0t ns: unexpected result, expected none, actual top_value %0h",
						$time, top_value);
				mismatch_cnt++;
			end else begin
				exp_r = results_q.pop_front();
				check_field("top_value", exp_r.top, top_value);
				check_field("is_empty", exp_r.empty, is_empty);
				check_field("is_full", exp_r.full, is_full);
				check_field("entry_count", exp_r.count, entry_count);
				check_field("found", exp_r.found, found);
				check_field("overflow", exp_r.ovf, overflow);
			end
		end
	end

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return DATA_W'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(mode_t m, logic [DATA_W-1:0] pv, logic [DATA_W-1:0] key);
		start      <= 1'b1;
		mode       <= m;
		push_value <= pv;
		search_key <= key;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		results_q.push_back(apply_stack_op(m, pv, key));
		requests_sent++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic issue(mode_t m);
		logic [DATA_W-1:0] key;
		if (stack_cnt > 0 && $urandom_range(0, 1))
			key = stack_mem[$urandom_range(0, stack_cnt - 1)];
		else
			key = rand_word();
		send_request(m, rand_word(), key);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (results_q.size() != 0);
	endtask

	function automatic mode_t pick_mode(int push_w, int pop_w, bit allow_clear);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_w)
			return MODE_PUSH;
		if (r < push_w + pop_w)
			return MODE_POP;
		case ($urandom_range(0, 9))
			4: return MODE_REVERSE;
			5: return MODE_SORT_MIN;
			6: return MODE_SORT_MAX;
			7: return allow_clear ? MODE_CLEAR : MODE_SEARCH;
			8: return MODE_NOP;
			default: return MODE_SEARCH;
		endcase
	endfunction

	task automatic test_directed();
		send_request(MODE_POP, 32'h1234_5678, 32'h0);
		send_request(MODE_SEARCH, 32'h0, 32'h0);
		send_request(MODE_REVERSE, 32'h0, 32'h0);
		send_request(MODE_SORT_MIN, 32'h0, 32'h0);
		send_request(MODE_PUSH, 32'h8000_0000, 32'hffff_ffff);
		send_request(MODE_SORT_MAX, 32'h0, 32'h0);
		send_request(MODE_REVERSE, 32'h0, 32'h0);
		send_request(MODE_PUSH, 32'h7fff_ffff, 32'h0);
		send_request(MODE_PUSH, 32'h0, 32'h0);
		send_request(MODE_PUSH, 32'hffff_ffff, 32'h0);
		send_request(MODE_SEARCH, 32'h0, 32'h8000_0000);
		send_request(MODE_SEARCH, 32'h0, 32'h0000_0005);
		send_request(MODE_SORT_MIN, 32'h0, 32'h0);
		send_request(MODE_SORT_MAX, 32'h0, 32'h0);
		send_request(MODE_REVERSE, 32'h0, 32'h0);
		send_request(MODE_NOP, 32'hffff_ffff, 32'hffff_ffff);
		send_request(MODE_PUSH, 32'h1, 32'h0);
		send_request(MODE_POP, 32'h0, 32'h0);
		send_request(MODE_POP, 32'h0, 32'h0);
		send_request(MODE_CLEAR, 32'h0, 32'h0);
		send_request(MODE_POP, 32'h0, 32'h0);
		send_request(MODE_PUSH, 32'h5555_5555, 32'h0);
		send_request(MODE_PUSH, 32'haaaa_aaaa, 32'h0);
		send_request(MODE_SEARCH, 32'h0, 32'haaaa_aaaa);
		wait_all_results();
	endtask

	// fill to full and past it, drain to empty and past it, mixed traffic
	task automatic test_random_traffic(int n_items);
		int last;
		int guard;
		last = requests_sent + n_items;
		while (requests_sent < last) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 2))
				0: begin
					guard = 0;
					while (stack_cnt < DEPTH && guard < 300) begin
						issue(pick_mode(85, 3, 1'b0));
						guard++;
					end
					repeat ($urandom_range(1, 3)) issue(MODE_PUSH);
					issue(pick_mode(0, 0, 1'b0));
				end
				1: begin
					guard = 0;
					while (stack_cnt > 0 && guard < 300) begin
						issue(pick_mode(5, 80, 1'b0));
						guard++;
					end
					repeat ($urandom_range(1, 2)) issue(MODE_POP);
					issue(pick_mode(0, 0, 1'b0));
				end
				default: begin
					repeat ($urandom_range(20, 60)) issue(pick_mode(35, 30, 1'b1));
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				wait_all_results();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_back_to_back(int n_items);
		gaps_on = 1'b0;
		repeat (n_items) issue(pick_mode(40, 30, 1'b1));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(880);
		test_back_to_back(100);
		wait_all_results();
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_cnt == 0 && results_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
sv/lss_pkg.sv
sv/lss_cell.sv
sv/lifo_stack_with_search_sort_top.sv
sim/lifo_stack_with_search_sort_top_tb.sv
